// ----- rtl/core/cau_pkg.sv -----
// ----------------------------------------------------------------------------
// cau_pkg: complex arithmetic unit shared definitions
// Beat types, operation codes, internal widths and the saturation helper.
// ----------------------------------------------------------------------------
package cau_pkg;

    localparam int WORD_WIDTH = 16;
    localparam int FRAC_BITS  = 8;

    localparam int PW = 2 * WORD_WIDTH;
    localparam int MW = 2 * WORD_WIDTH + 1;
    localparam int QW = WORD_WIDTH + 2;
    localparam int RW = 3 * WORD_WIDTH + FRAC_BITS + 2;

    localparam logic [2:0] KIND_ADD = 3'd0;
    localparam logic [2:0] KIND_SUB = 3'd1;
    localparam logic [2:0] KIND_MUL = 3'd2;
    localparam logic [2:0] KIND_DIV = 3'd3;
    localparam logic [2:0] KIND_EQ  = 3'd4;
    localparam logic [2:0] KIND_NE  = 3'd5;

    localparam logic [MW-1:0] NEG_MAX_M = MW'(1) << (WORD_WIDTH - 1);
    localparam logic [MW-1:0] POS_MAX_M = NEG_MAX_M - MW'(1);

    typedef struct packed {
        logic [2:0]                   kind;
        logic signed [WORD_WIDTH-1:0] a_re;
        logic signed [WORD_WIDTH-1:0] a_im;
        logic signed [WORD_WIDTH-1:0] b_re;
        logic signed [WORD_WIDTH-1:0] b_im;
    } op_t;

    typedef struct packed {
        logic signed [WORD_WIDTH-1:0] res_re;
        logic signed [WORD_WIDTH-1:0] res_im;
        logic                         is_true;
        logic                         div_by_zero;
        logic                         saturated;
    } res_t;

    typedef struct packed {
        logic          is_div;
        logic          neg_re;
        logic          neg_im;
        logic [RW-1:0] rem_re;
        logic [RW-1:0] rem_im;
        logic [PW-1:0] den;
        logic [QW-1:0] q_re;
        logic [QW-1:0] q_im;
        res_t          pre;
    } cell_t;

    // {saturated, word} from sign and magnitude
    function automatic logic [WORD_WIDTH:0] sat_word(input logic neg, input logic [MW-1:0] mag);
        logic [MW-1:0] lim;
        logic          sat;
        logic [MW-1:0] m;
        lim = neg ? NEG_MAX_M : POS_MAX_M;
        sat = mag > lim;
        m   = sat ? lim : mag;
        m   = neg ? (MW'(0) - m) : m;
        return {sat, m[WORD_WIDTH-1:0]};
    endfunction

endpackage

// ----- rtl/core/complex_arithmetic_unit_top.sv -----
// ----------------------------------------------------------------------------
// complex_arithmetic_unit_top: complex number ALU, signed Q8.8
// Add, subtract, multiply, divide and compare of two complex operands.
// ----------------------------------------------------------------------------
// Usage:
//   Operand beats enter on op / op_valid, held back by op_stall. Result beats
//   leave on res / res_valid, held back by res_stall. One result per operand.
//   The pipeline is one product stage, one setup stage, 18 divider cells
//   (one quotient bit each, WORD_WIDTH + 2 cells) and the output register.
//   Every operation takes the same path, so results leave in order.
//   Throughput is one beat per cycle while res_stall stays low.
//   When res_stall is high with a result waiting, the whole pipeline holds
//   and op_stall rises in the same cycle; nothing is dropped.
//   Reset clears all valid bits; the first beat may enter right after it.
//   Divide by zero returns zero parts with div_by_zero set. Compares return
//   zero parts with is_true. Unused kinds return an all-zero beat.
// ----------------------------------------------------------------------------
module complex_arithmetic_unit_top (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           op_valid,
    output logic           op_stall,
    input  cau_pkg::op_t   op,
    output logic           res_valid,
    input  logic           res_stall,
    output cau_pkg::res_t  res
);
    import cau_pkg::*;

    logic                 adv;
    logic                 chain_valid [0:QW];
    cell_t                chain_beat  [0:QW];
    logic                 res_valid_reg;
    res_t                 res_reg;
    res_t                 res_next;
    logic [WORD_WIDTH:0]  q_re_w, q_im_w;

    assign adv      = !res_valid_reg || !res_stall;
    assign op_stall = !adv;

    cau_prep u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .op_valid  (op_valid),
        .op        (op),
        .valid_out (chain_valid[0]),
        .beat_out  (chain_beat[0])
    );

    for (genvar i = 0; i < QW; i++)
    begin : g_cell
        cau_div_cell #(
            .BIT_POS (QW - 1 - i)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .adv       (adv),
            .valid_in  (chain_valid[i]),
            .beat_in   (chain_beat[i]),
            .valid_out (chain_valid[i+1]),
            .beat_out  (chain_beat[i+1])
        );
    end

    always_comb
    begin
        q_re_w   = sat_word(chain_beat[QW].neg_re, MW'(chain_beat[QW].q_re));
        q_im_w   = sat_word(chain_beat[QW].neg_im, MW'(chain_beat[QW].q_im));
        res_next = chain_beat[QW].pre;
        if (chain_beat[QW].is_div)
        begin
            res_next.res_re    = q_re_w[WORD_WIDTH-1:0];
            res_next.res_im    = q_im_w[WORD_WIDTH-1:0];
            res_next.saturated = q_re_w[WORD_WIDTH] | q_im_w[WORD_WIDTH];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            res_valid_reg <= chain_valid[QW];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            res_reg <= res_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    a_dz_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_reg.div_by_zero) |->
            (res_reg.res_re == '0 && res_reg.res_im == '0 && !res_reg.saturated))
        else $error("divide by zero beat carries data");

    a_cmp_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_reg.is_true) |->
            (res_reg.res_re == '0 && res_reg.res_im == '0 && !res_reg.div_by_zero))
        else $error("compare beat carries data");

    a_sat_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_reg.saturated) |->
            (res_reg.res_re == WORD_WIDTH'(POS_MAX_M) || res_reg.res_re == WORD_WIDTH'(NEG_MAX_M)
             || res_reg.res_im == WORD_WIDTH'(POS_MAX_M)
             || res_reg.res_im == WORD_WIDTH'(NEG_MAX_M)))
        else $error("saturated beat not at a bound");

    a_hold_chain: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_stall) |=> $stable(chain_valid[QW]))
        else $error("pipeline moved under stall");

endmodule

// ----- rtl/core/cau_prep.sv -----
// ----------------------------------------------------------------------------
// cau_prep: operand products and divider setup
// Forms all products, finishes add, subtract, multiply and compare, and
// loads sign, magnitude and denominator for the divider cells.
// ----------------------------------------------------------------------------
module cau_prep (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            adv,
    input  logic            op_valid,
    input  cau_pkg::op_t    op,
    output logic            valid_out,
    output cau_pkg::cell_t  beat_out
);
    import cau_pkg::*;

    logic                         va_reg;
    logic [2:0]                   kind_reg;
    logic signed [PW-1:0]         rr_reg, ii_reg, ri_reg, ir_reg, sr_reg, si_reg;
    logic signed [WORD_WIDTH:0]   sum_re_reg, sum_im_reg;
    logic                         eq_reg;

    logic                         vb_reg;
    cell_t                        beat_reg;
    cell_t                        beat_next;

    logic signed [MW-1:0]         rr, ii, ri, ir, re_s, im_s, as_re, as_im;
    logic [MW-1:0]                mag_re, mag_im, amag_re, amag_im;
    logic                         neg_re, neg_im, aneg_re, aneg_im;
    logic [PW-1:0]                den;
    logic [WORD_WIDTH:0]          sw_re, sw_im;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end
        else if (adv)
        begin
            va_reg <= op_valid;
            vb_reg <= va_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            kind_reg <= op.kind;
            rr_reg   <= op.a_re * op.b_re;
            ii_reg   <= op.a_im * op.b_im;
            ri_reg   <= op.a_re * op.b_im;
            ir_reg   <= op.a_im * op.b_re;
            sr_reg   <= op.b_re * op.b_re;
            si_reg   <= op.b_im * op.b_im;
            if (op.kind == KIND_SUB)
            begin
                sum_re_reg <= (WORD_WIDTH+1)'(op.a_re) - (WORD_WIDTH+1)'(op.b_re);
                sum_im_reg <= (WORD_WIDTH+1)'(op.a_im) - (WORD_WIDTH+1)'(op.b_im);
            end
            else
            begin
                sum_re_reg <= (WORD_WIDTH+1)'(op.a_re) + (WORD_WIDTH+1)'(op.b_re);
                sum_im_reg <= (WORD_WIDTH+1)'(op.a_im) + (WORD_WIDTH+1)'(op.b_im);
            end
            eq_reg   <= (op.a_re == op.b_re) && (op.a_im == op.b_im);
            beat_reg <= beat_next;
        end
    end

    always_comb
    begin
        rr = MW'(rr_reg);
        ii = MW'(ii_reg);
        ri = MW'(ri_reg);
        ir = MW'(ir_reg);
        if (kind_reg == KIND_DIV)
        begin
            re_s = rr + ii;
            im_s = ir - ri;
        end
        else
        begin
            re_s = rr - ii;
            im_s = ri + ir;
        end
        neg_re = re_s[MW-1];
        neg_im = im_s[MW-1];
        mag_re = neg_re ? MW'(-re_s) : MW'(re_s);
        mag_im = neg_im ? MW'(-im_s) : MW'(im_s);
        den    = PW'($unsigned(sr_reg) + $unsigned(si_reg));

        as_re   = MW'(sum_re_reg);
        as_im   = MW'(sum_im_reg);
        aneg_re = as_re[MW-1];
        aneg_im = as_im[MW-1];
        amag_re = aneg_re ? MW'(-as_re) : MW'(as_re);
        amag_im = aneg_im ? MW'(-as_im) : MW'(as_im);

        sw_re = '0;
        sw_im = '0;

        beat_next        = '0;
        beat_next.neg_re = neg_re;
        beat_next.neg_im = neg_im;
        beat_next.rem_re = RW'(mag_re) << FRAC_BITS;
        beat_next.rem_im = RW'(mag_im) << FRAC_BITS;
        beat_next.den    = den;

        case (kind_reg)
            KIND_ADD, KIND_SUB:
            begin
                sw_re = sat_word(aneg_re, amag_re);
                sw_im = sat_word(aneg_im, amag_im);
                beat_next.pre.res_re    = sw_re[WORD_WIDTH-1:0];
                beat_next.pre.res_im    = sw_im[WORD_WIDTH-1:0];
                beat_next.pre.saturated = sw_re[WORD_WIDTH] | sw_im[WORD_WIDTH];
            end
            KIND_MUL:
            begin
                sw_re = sat_word(neg_re, mag_re >> FRAC_BITS);
                sw_im = sat_word(neg_im, mag_im >> FRAC_BITS);
                beat_next.pre.res_re    = sw_re[WORD_WIDTH-1:0];
                beat_next.pre.res_im    = sw_im[WORD_WIDTH-1:0];
                beat_next.pre.saturated = sw_re[WORD_WIDTH] | sw_im[WORD_WIDTH];
            end
            KIND_DIV:
            begin
                beat_next.is_div          = den != '0;
                beat_next.pre.div_by_zero = den == '0;
            end
            KIND_EQ:
            begin
                beat_next.pre.is_true = eq_reg;
            end
            KIND_NE:
            begin
                beat_next.pre.is_true = !eq_reg;
            end
            default:
            begin
                beat_next.is_div = 1'b0;
            end
        endcase
    end

    assign valid_out = vb_reg;
    assign beat_out  = beat_reg;

endmodule

// ----- rtl/core/cau_div_cell.sv -----
// ----------------------------------------------------------------------------
// cau_div_cell: one restoring-division cell
// Resolves one quotient bit for both result parts and hands the beat on.
// ----------------------------------------------------------------------------
module cau_div_cell #(
    parameter int BIT_POS = 0
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            adv,
    input  logic            valid_in,
    input  cau_pkg::cell_t  beat_in,
    output logic            valid_out,
    output cau_pkg::cell_t  beat_out
);
    import cau_pkg::*;

    logic          valid_reg;
    cell_t         beat_reg;
    cell_t         beat_next;
    logic [RW-1:0] den_sh;

    always_comb
    begin
        den_sh    = RW'(beat_in.den) << BIT_POS;
        beat_next = beat_in;
        if (beat_in.rem_re >= den_sh)
        begin
            beat_next.rem_re         = beat_in.rem_re - den_sh;
            beat_next.q_re[BIT_POS]  = 1'b1;
        end
        if (beat_in.rem_im >= den_sh)
        begin
            beat_next.rem_im         = beat_in.rem_im - den_sh;
            beat_next.q_im[BIT_POS]  = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            beat_reg <= beat_next;
        end
    end

    assign valid_out = valid_reg;
    assign beat_out  = beat_reg;

endmodule

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb: complex arithmetic unit testbench
// Drives operand beats in random bursts against a stalling result side and
// checks every result beat against a fixed-point complex ALU predictor.
// ----------------------------------------------------------------------------
module tb;
    import cau_pkg::*;

    logic clk;
    logic rst_n;
    logic op_valid;
    logic op_stall;
    op_t  op;
    logic res_valid;
    logic res_stall;
    res_t res;

    op_t    pending_ops[$];
    res_t   expected_res[$];
    int     errors;
    bit     feeding_done;
    int     gap_left;
    int     burst_left;
    bit     op_taken;

    complex_arithmetic_unit_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .op_valid  (op_valid),
        .op_stall  (op_stall),
        .op        (op),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    function automatic logic [WORD_WIDTH:0] clip(input logic signed [63:0] v);
        if (v > 64'sd32767)
            return {1'b1, 16'sh7fff};
        if (v < -64'sd32768)
            return {1'b1, 16'sh8000};
        return {1'b0, v[15:0]};
    endfunction

    // truncate toward zero: floor of magnitude
    function automatic logic signed [63:0] trunc_div(input logic signed [63:0] num,
                                                    input logic signed [63:0] den);
        logic signed [63:0] m;
        m = (num < 0) ? -num : num;
        m = (m <<< FRAC_BITS) / den;
        return (num < 0) ? -m : m;
    endfunction

    function automatic res_t alu_predict(input op_t x);
        res_t               r;
        logic signed [63:0] ar, ai, br, bi, sr, si, den;
        logic [WORD_WIDTH:0] cr, ci;
        ar = x.a_re;
        ai = x.a_im;
        br = x.b_re;
        bi = x.b_im;
        r  = '0;
        sr = 0;
        si = 0;
        case (x.kind)
            KIND_ADD, KIND_SUB, KIND_MUL, KIND_DIV:
            begin
                if (x.kind == KIND_ADD)
                begin
                    sr = ar + br;
                    si = ai + bi;
                end
                else if (x.kind == KIND_SUB)
                begin
                    sr = ar - br;
                    si = ai - bi;
                end
                else if (x.kind == KIND_MUL)
                begin
                    sr = ar * br - ai * bi;
                    si = ar * bi + ai * br;
                    sr = (sr < 0) ? -((-sr) >>> FRAC_BITS) : (sr >>> FRAC_BITS);
                    si = (si < 0) ? -((-si) >>> FRAC_BITS) : (si >>> FRAC_BITS);
                end
                else
                begin
                    den = br * br + bi * bi;
                    if (den != 0)
                    begin
                        sr = trunc_div(ar * br + ai * bi, den);
                        si = trunc_div(ai * br - ar * bi, den);
                    end
                    else
                        r.div_by_zero = 1'b1;
                end
                if (!r.div_by_zero)
                begin
                    cr = clip(sr);
                    ci = clip(si);
                    r.res_re    = cr[WORD_WIDTH-1:0];
                    r.res_im    = ci[WORD_WIDTH-1:0];
                    r.saturated = cr[WORD_WIDTH] | ci[WORD_WIDTH];
                end
            end
            KIND_EQ:
                r.is_true = (ar == br) && (ai == bi);
            KIND_NE:
                r.is_true = !((ar == br) && (ai == bi));
            default:
                r = '0;
        endcase
        return r;
    endfunction

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("error: %s got %0h expected %0h", what, got, want);
        errors++;
    endtask

    function automatic logic [15:0] rand_word();
        case ($urandom_range(0, 9))
            0: return 16'h7fff;
            1: return 16'h8000;
            2: return 16'h0000;
            3: return 16'(int'($urandom_range(0, 1024)) - 512);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic add_op(input logic [2:0] k, input logic [15:0] p, input logic [15:0] q,
                          input logic [15:0] s, input logic [15:0] t);
        op_t x;
        x.kind = k;
        x.a_re = p;
        x.a_im = q;
        x.b_re = s;
        x.b_im = t;
        pending_ops.push_back(x);
    endtask

    // driver: bursts with gaps, falling edge
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (op_taken)
            begin
                void'(pending_ops.pop_front());
                if (burst_left > 0)
                    burst_left--;
            end
            if (op_valid && !op_taken)
            begin
                // hold stalled beat
            end
            else if (pending_ops.size() > 0 && (burst_left > 0 || gap_left == 0))
            begin
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 30);
                    gap_left   = $urandom_range(0, 1) ? 0 : $urandom_range(1, 6);
                end
                op_valid <= 1'b1;
                op       <= pending_ops[0];
            end
            else
            begin
                if (gap_left > 0)
                    gap_left--;
                op_valid <= 1'b0;
            end
            case (($urandom_range(0, 3) == 0) ? 1 : 0)
                1: res_stall <= ($urandom_range(0, 2) == 0);
                default: res_stall <= ($urandom_range(0, 15) == 0) ? 1'b1 : 1'b0;
            endcase
        end
    end

    always @(posedge clk)
    begin
        op_taken = rst_n && op_valid && !op_stall;
        if (op_taken)
            expected_res.push_back(alu_predict(op));
        if (rst_n && res_valid && !res_stall)
        begin
            if (expected_res.size() == 0)
                report("unexpected beat", 32'(res), 32'h0);
            else
            begin
                if (res.res_re !== expected_res[0].res_re)
                    report("res_re", 32'(res.res_re), 32'(expected_res[0].res_re));
                if (res.res_im !== expected_res[0].res_im)
                    report("res_im", 32'(res.res_im), 32'(expected_res[0].res_im));
                if (res.is_true !== expected_res[0].is_true)
                    report("is_true", 32'(res.is_true), 32'(expected_res[0].is_true));
                if (res.div_by_zero !== expected_res[0].div_by_zero)
                    report("div_by_zero", 32'(res.div_by_zero),
                           32'(expected_res[0].div_by_zero));
                if (res.saturated !== expected_res[0].saturated)
                    report("saturated", 32'(res.saturated), 32'(expected_res[0].saturated));
                void'(expected_res.pop_front());
            end
        end
    end

    initial
    begin
        logic [15:0] w, v;
        errors     = 0;
        gap_left   = 0;
        burst_left = 0;
        op_taken   = 1'b0;
        rst_n      = 1'b0;
        op_valid   = 1'b0;
        op         = '0;
        res_stall  = 1'b0;
        add_op(KIND_ADD, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000);
        add_op(KIND_SUB, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff);
        add_op(KIND_ADD, 16'h0100, 16'hff00, 16'h0080, 16'h0040);
        add_op(KIND_MUL, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
        add_op(KIND_MUL, 16'h0100, 16'h0200, 16'h0300, 16'hfc00);
        add_op(KIND_MUL, 16'hffff, 16'h0000, 16'h0001, 16'h0000);
        add_op(KIND_MUL, 16'h7fff, 16'h7fff, 16'h7fff, 16'h8000);
        add_op(KIND_DIV, 16'h0100, 16'h0100, 16'h0000, 16'h0000);
        add_op(KIND_DIV, 16'h0300, 16'hfd00, 16'h0100, 16'h0100);
        add_op(KIND_DIV, 16'h7fff, 16'h8000, 16'h0001, 16'h0000);
        add_op(KIND_DIV, 16'hffff, 16'h0001, 16'h7fff, 16'h8000);
        add_op(KIND_DIV, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
        add_op(KIND_DIV, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        add_op(KIND_EQ, 16'h1234, 16'h8000, 16'h1234, 16'h8000);
        add_op(KIND_EQ, 16'h1234, 16'h8000, 16'h1234, 16'h8001);
        add_op(KIND_NE, 16'h7fff, 16'h0000, 16'h7fff, 16'h0000);
        add_op(KIND_NE, 16'h7fff, 16'h0000, 16'h7ffe, 16'h0000);
        add_op(3'd6, 16'h7fff, 16'h8000, 16'h0001, 16'h0001);
        add_op(3'd7, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
        repeat (1900)
        begin
            w = rand_word();
            v = rand_word();
            if ($urandom_range(0, 3) == 0)
                add_op(3'($urandom_range(0, 7)), w, v, w, v);
            else
                add_op(3'($urandom_range(0, 7)), w, v, rand_word(), rand_word());
        end
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        wait (pending_ops.size() == 0);
        wait (expected_res.size() == 0);
        repeat (40) @(posedge clk);
        if (errors == 0)
            $display("complex_arithmetic_unit_top: match");
        else
            $display("complex_arithmetic_unit_top: mismatch");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("complex_arithmetic_unit_top: mismatch");
        $finish;
    end
endmodule

// ----- files.f -----
rtl/core/cau_pkg.sv
rtl/core/cau_prep.sv
rtl/core/cau_div_cell.sv
rtl/core/complex_arithmetic_unit_top.sv
tb/tb.sv
